// ===== hdl/werol_pkg.sv =====
`default_nettype none

package werol_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [0:0] {
        FUNC_ADD  = 1'b0,
        FUNC_FIND = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_CHECK  = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] handle;
        logic [DATA_W-1:0] size;
        logic [DATA_W-1:0] offset;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/werol_out_stage.sv =====
`default_nettype none

module werol_out_stage (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    input  wire werol_pkg::result_t              push_data,
    output logic                                 push_ready,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // found_handle, found_size, byte_offset
    output logic [3*werol_pkg::DATA_W-1:0]       m_tdata,
    // found
    output logic [0:0]                           m_tuser
);

    logic               valid_reg;
    logic               valid_next;
    werol_pkg::result_t data_reg;

    assign push_ready = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= push_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {data_reg.offset, data_reg.size, data_reg.handle};
    assign m_tuser  = data_reg.found;

endmodule

`default_nettype wire

// ===== hdl/write_entry_ring_offset_lookup.sv =====
`default_nettype none

// Channel  Direction  tdata (low bit up)                                    tuser
// s_axis   in         entry_handle, entry_size, char_position (96 bits)     func
// m_axis   out        found_handle, found_size, byte_offset (96 bits)       found
//
// An add writes the record to the ring memory as soon as it is accepted.
// A find walks the stored records from the oldest, reading one record per cycle from
// the ring memory, and stops at the first that holds the position (found) or after
// the last of at most RING_DEPTH records (not found); an empty ring skips the walk.
// Reset clears the slot pointers and the record count; the memory needs no clearing.
// A result waits in the output register; a stalled output holds the find in
// its result state, while the next item is taken once that register frees.

module write_entry_ring_offset_lookup #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // entry_handle, entry_size, char_position
    input  wire logic [3*werol_pkg::DATA_W-1:0]    s_tdata,
    // func
    input  wire logic [0:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // found_handle, found_size, byte_offset
    output logic [3*werol_pkg::DATA_W-1:0]         m_tdata,
    // found
    output logic [0:0]                             m_tuser
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int DW    = werol_pkg::DATA_W;

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(RING_DEPTH);

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] slot);
        logic [PTR_W-1:0] res;
        if (slot == LAST_SLOT)
        begin
            res = '0;
        end
        else
        begin
            res = slot + PTR_W'(1);
        end
        return res;
    endfunction

    logic [DW-1:0] in_handle;
    logic [DW-1:0] in_size;
    logic [DW-1:0] in_pos;

    assign in_handle = s_tdata[DW-1:0];
    assign in_size   = s_tdata[2*DW-1:DW];
    assign in_pos    = s_tdata[3*DW-1:2*DW];

    werol_pkg::state_t  state_reg, state_next;
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   oldest_reg, oldest_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic [DW-1:0]      rem_reg, rem_next;
    werol_pkg::result_t res_reg, res_next;

    logic [2*DW-1:0]    ring_mem [RING_DEPTH];
    logic [2*DW-1:0]    rd_data_reg;
    logic               wr_en;
    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;

    logic               push;
    logic               push_ready;
    logic [DW-1:0]      rec_handle;
    logic [DW-1:0]      rec_size;

    assign rec_handle = rd_data_reg[DW-1:0];
    assign rec_size   = rd_data_reg[2*DW-1:DW];

    assign s_tready = (state_reg == werol_pkg::ST_IDLE);
    assign push     = (state_reg == werol_pkg::ST_RESULT) && push_ready;

    always_comb
    begin
        state_next  = state_reg;
        wr_next     = wr_reg;
        oldest_next = oldest_reg;
        count_next  = count_reg;
        slot_next   = slot_reg;
        left_next   = left_reg;
        rem_next    = rem_reg;
        res_next    = res_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = slot_reg;

        unique case (state_reg)
            werol_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser[0] == werol_pkg::FUNC_ADD)
                    begin
                        wr_en   = 1'b1;
                        wr_next = next_slot(wr_reg);
                        if (count_reg == FULL_CNT)
                        begin
                            oldest_next = next_slot(oldest_reg);
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        rem_next = in_pos;
                        if (count_reg == '0)
                        begin
                            res_next   = '0;
                            state_next = werol_pkg::ST_RESULT;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = oldest_reg;
                            slot_next  = next_slot(oldest_reg);
                            left_next  = count_reg - CNT_W'(1);
                            state_next = werol_pkg::ST_CHECK;
                        end
                    end
                end
            end
            werol_pkg::ST_CHECK:
            begin
                if (rem_reg < rec_size)
                begin
                    res_next.found  = 1'b1;
                    res_next.handle = rec_handle;
                    res_next.size   = rec_size;
                    res_next.offset = rem_reg;
                    state_next      = werol_pkg::ST_RESULT;
                end
                else if (left_reg == '0)
                begin
                    res_next   = '0;
                    state_next = werol_pkg::ST_RESULT;
                end
                else
                begin
                    rem_next  = rem_reg - rec_size;
                    rd_en     = 1'b1;
                    rd_addr   = slot_reg;
                    slot_next = next_slot(slot_reg);
                    left_next = left_reg - CNT_W'(1);
                end
            end
            werol_pkg::ST_RESULT:
            begin
                if (push_ready)
                begin
                    state_next = werol_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = werol_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= werol_pkg::ST_IDLE;
            wr_reg     <= '0;
            oldest_reg <= '0;
            count_reg  <= '0;
            slot_reg   <= '0;
            left_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            wr_reg     <= wr_next;
            oldest_reg <= oldest_next;
            count_reg  <= count_next;
            slot_reg   <= slot_next;
            left_reg   <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_reg] <= {in_size, in_handle};
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    werol_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (res_reg),
        .push_ready (push_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("record count exceeds ring depth");

    a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == FULL_CNT) |-> (wr_reg == oldest_reg))
        else $error("full ring with write slot apart from oldest slot");

    a_fill_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != FULL_CNT) |-> (oldest_reg == '0) && (CNT_W'(wr_reg) == count_reg))
        else $error("ring that never filled has moved its oldest slot");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == werol_pkg::ST_CHECK) |-> (left_reg < count_reg) && $stable(count_reg))
        else $error("find walk runs past the stored records");

    a_ring_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != werol_pkg::ST_IDLE) |-> !wr_en)
        else $error("ring written during a find");
`endif

endmodule

`default_nettype wire
